@@ src/lsbc_pkg.sv @@
// Types, widths and helpers shared by the line segment band clip block.
// No dependencies.
`timescale 1ns / 1ps
package lsbc_pkg;

  localparam int COORD_BITS = 24;
  localparam int CW = COORD_BITS;
  localparam int YW = CW + 2;   // shifted coordinates and band limits
  localparam int XW = CW + 1;   // shifted X

  typedef struct packed {
    logic                 visible;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] second_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] x_base;
    logic signed [CW-1:0] y_base;
    logic        [CW-2:0] height_printed;
    logic        [CW-2:0] height_to_print;
  } seg_t;

  typedef struct packed {
    logic                 show;
    logic signed [CW-1:0] out_x1;
    logic signed [CW-1:0] out_y1;
    logic signed [CW-1:0] out_x2;
    logic signed [CW-1:0] out_y2;
  } clip_t;

  // Data that rides along the divider chain unchanged.
  typedef struct packed {
    logic                 show;
    logic                 clip_top;
    logic                 clip_bot;
    logic                 dx_neg;
    logic signed [XW-1:0] x1;
    logic signed [XW-1:0] x2;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] y2;
  } side_t;

  // One restoring divider: partial remainder, unused dividend bits, quotient.
  typedef struct packed {
    logic [CW-1:0] rem;
    logic [CW-1:0] low;
    logic [CW-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic          valid;
    side_t         side;
    logic [CW-1:0] den;
    lane_t         top;
    lane_t         bot;
  } stage_t;

  localparam logic signed [YW-1:0] SAT_MAX = YW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [YW-1:0] SAT_MIN = -SAT_MAX - YW'(1);

  function automatic logic signed [CW-1:0] sat(input logic signed [YW-1:0] v);
    logic signed [YW-1:0] c;
    begin
      c = v;
      if (v > SAT_MAX) c = SAT_MAX;
      if (v < SAT_MIN) c = SAT_MIN;
      sat = c[CW-1:0];
    end
  endfunction

endpackage

@@ src/lsbc_front.sv @@
// Front end: orders and shifts endpoints, decides visibility and clipping,
// and forms the two products for the dividers. Uses lsbc_pkg.
`timescale 1ns / 1ps
module lsbc_front import lsbc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  seg_t   in_seg,
  output stage_t out
);

  // first register: ordered and shifted endpoints, band limits
  logic                 v1, vis1;
  logic signed [YW-1:0] y1a, y2a, lim1a, lim2a;
  logic signed [XW-1:0] x1a, x2a;

  logic                 swap;
  logic signed [YW-1:0] ya_c, yb_c, yoff, ybase_e;
  logic signed [XW-1:0] xa_c, xb_c;

  always_comb begin
    swap    = !(in_seg.first_y < in_seg.second_y);
    ybase_e = YW'(in_seg.y_base);
    yoff    = ybase_e - $signed({3'b000, in_seg.height_printed});
    ya_c    = (swap ? YW'(in_seg.second_y) : YW'(in_seg.first_y)) + yoff;
    yb_c    = (swap ? YW'(in_seg.first_y) : YW'(in_seg.second_y)) + yoff;
    xa_c    = (swap ? XW'(in_seg.second_x) : XW'(in_seg.first_x)) + XW'(in_seg.x_base);
    xb_c    = (swap ? XW'(in_seg.first_x) : XW'(in_seg.second_x)) + XW'(in_seg.x_base);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      vis1  <= in_seg.visible;
      y1a   <= ya_c;
      y2a   <= yb_c;
      x1a   <= xa_c;
      x2a   <= xb_c;
      lim1a <= ybase_e;
      lim2a <= ybase_e + $signed({3'b000, in_seg.height_to_print}) - YW'(1);
    end
  end

  // second register: decisions and divider operands
  logic                 v2;
  side_t                side2;
  logic [CW-1:0]        tt2, tb2, dxm2, den2;

  logic                 flat, show_c, ct_c, cb_c;
  logic signed [YW-1:0] dx_c, tt_c, tb_c, dy_c, dxm_c;

  always_comb begin
    flat  = (y1a == y2a);
    ct_c  = y1a < lim1a;
    cb_c  = y2a > lim2a;
    if (flat) begin
      show_c = vis1 && (y1a >= lim1a) && (y1a <= lim2a);
    end else begin
      show_c = vis1 && !((y1a > lim2a) || (y2a < lim1a));
    end
    dx_c  = YW'(x2a) - YW'(x1a);
    dxm_c = dx_c[YW-1] ? -dx_c : dx_c;
    tt_c  = lim1a - y1a;
    tb_c  = lim2a - y1a;
    dy_c  = y2a - y1a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      side2.show     <= show_c;
      side2.clip_top <= !flat && ct_c;
      side2.clip_bot <= !flat && cb_c;
      side2.dx_neg   <= dx_c[YW-1];
      side2.x1       <= x1a;
      side2.x2       <= x2a;
      side2.y1       <= sat((!flat && ct_c) ? lim1a : y1a);
      side2.y2       <= sat((!flat && cb_c) ? lim2a : y2a);
      tt2            <= tt_c[CW-1:0];
      tb2            <= tb_c[CW-1:0];
      dxm2           <= dxm_c[CW-1:0];
      den2           <= dy_c[CW-1:0];
    end
  end

  // third register: products split into remainder seed and low bits
  logic [2*CW-1:0] pt_c, pb_c;

  always_comb begin
    pt_c = tt2 * dxm2;
    pb_c = tb2 * dxm2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= v2;
    end
    if (en) begin
      out.side     <= side2;
      out.den      <= den2;
      out.top.rem  <= pt_c[2*CW-1:CW];
      out.top.low  <= pt_c[CW-1:0];
      out.top.quo  <= '0;
      out.bot.rem  <= pb_c[2*CW-1:CW];
      out.bot.low  <= pb_c[CW-1:0];
      out.bot.quo  <= '0;
    end
  end

endmodule

@@ src/lsbc_cell.sv @@
// One divider cell: a restoring step for both clip ends, one quotient bit each.
// Uses lsbc_pkg.
`timescale 1ns / 1ps
module lsbc_cell import lsbc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  stage_t prev,
  output stage_t next
);

  function automatic lane_t step(input lane_t l, input logic [CW-1:0] d);
    logic [CW:0] r2;
    logic        ge;
    begin
      r2       = {l.rem, l.low[CW-1]};
      ge       = r2 >= {1'b0, d};
      step.rem = ge ? CW'(r2 - {1'b0, d}) : r2[CW-1:0];
      step.low = {l.low[CW-2:0], 1'b0};
      step.quo = {l.quo[CW-2:0], ge};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (en) begin
      next.valid <= prev.valid;
    end
    if (en) begin
      next.side <= prev.side;
      next.den  <= prev.den;
      next.top  <= step(prev.top, prev.den);
      next.bot  <= step(prev.bot, prev.den);
    end
  end

endmodule

@@ src/line_segment_band_clip.sv @@
// Top level of the line segment band clip block: front end, divider cell chain,
// output register. Uses lsbc_pkg, lsbc_front, lsbc_cell.
//
//   channel | valid      | stall      | payload
//   input   | seg_valid  | seg_stall  | seg  (seg_t)
//   output  | clip_valid | clip_stall | clip (clip_t)
//
// One segment per cycle while the pipeline is not held. Stages: three front-end
// registers, one divider cell per quotient bit, and the output register.
// The whole pipeline holds while a result sits in the output register and
// clip_stall is high; seg_stall follows that condition.
// Reset (rst, synchronous) clears only the valid bits.
`timescale 1ns / 1ps
module line_segment_band_clip import lsbc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  seg_valid,
  output logic  seg_stall,
  input  seg_t  seg,
  output logic  clip_valid,
  input  logic  clip_stall,
  output clip_t clip
);

  logic   en;
  stage_t chain [0:CW];

  assign en        = !(clip_valid && clip_stall);
  assign seg_stall = !en;

  lsbc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (seg_valid),
    .in_seg   (seg),
    .out      (chain[0])
  );

  for (genvar i = 0; i < CW; i++) begin : g_cell
    lsbc_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (chain[i]),
      .next (chain[i+1])
    );
  end

  side_t                s;
  logic signed [YW-1:0] x1_c, x2_c, q1, q2;
  clip_t                res;

  always_comb begin
    s    = chain[CW].side;
    q1   = $signed({2'b00, chain[CW].top.quo});
    q2   = $signed({2'b00, chain[CW].bot.quo});
    x1_c = YW'(s.x1);
    x2_c = YW'(s.x2);
    if (s.clip_top) begin
      x1_c = s.dx_neg ? x1_c - q1 : x1_c + q1;
    end
    if (s.clip_bot) begin
      x2_c = s.dx_neg ? YW'(s.x1) - q2 : YW'(s.x1) + q2;
    end
    res.show   = s.show;
    res.out_x1 = s.show ? sat(x1_c) : '0;
    res.out_y1 = s.show ? s.y1 : '0;
    res.out_x2 = s.show ? sat(x2_c) : '0;
    res.out_y2 = s.show ? s.y2 : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_valid <= 1'b0;
    end else if (en) begin
      clip_valid <= chain[CW].valid;
    end
    if (en) begin
      clip <= res;
    end
  end

endmodule

@@ src/lsbc_checker.sv @@
// Port-level checks for line_segment_band_clip, bound to the top level.
// Uses lsbc_pkg.
`timescale 1ns / 1ps
module lsbc_checker import lsbc_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  seg_valid,
  input logic  seg_stall,
  input seg_t  seg,
  input logic  clip_valid,
  input logic  clip_stall,
  input clip_t clip
);

  // input is held back only by a waiting, stalled result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !(clip_valid && clip_stall) |-> !seg_stall)
    else $error("input stalled with no blocked result");

  a_back_press: assert property (@(posedge clk) disable iff (rst)
    (clip_valid && clip_stall) |-> seg_stall)
    else $error("input taken while result blocked");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (clip_valid && !clip.show) |-> (clip.out_x1 == '0 && clip.out_y1 == '0
      && clip.out_x2 == '0 && clip.out_y2 == '0))
    else $error("hidden segment carries coordinates");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (clip_valid && clip_stall) |=> (clip_valid && $stable(clip)))
    else $error("stalled beat changed");

endmodule

bind line_segment_band_clip lsbc_checker u_lsbc_checker (
  .clk        (clk),
  .rst        (rst),
  .seg_valid  (seg_valid),
  .seg_stall  (seg_stall),
  .seg        (seg),
  .clip_valid (clip_valid),
  .clip_stall (clip_stall),
  .clip       (clip)
);
